// ----- src/p80_pkg.sv -----
// Shared constants, types and round functions of the PRESENT-80 encryptor.
package p80_pkg;

  localparam int BLK_W     = 64;
  localparam int KEY_W     = 80;
  localparam int KEY_HI_W  = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int RK_DEPTH  = 32;
  localparam int RK_AW     = $clog2(RK_DEPTH);
  localparam int CNT_W     = 5;

  localparam logic [RK_AW-1:0] LAST_KEY = RK_AW'(RK_DEPTH - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // round key write request from the schedule unit to the store
  typedef struct packed {
    logic             we;
    logic [RK_AW-1:0] addr;
    logic [BLK_W-1:0] data;
  } ks_wr_t;

  function automatic logic [BLK_W-1:0] sbox_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    t = '0;
    for (int i = 0; i < BLK_W / 4; i++) begin
      t[4*i +: 4] = SBOX[s[4*i +: 4]];
    end
    return t;
  endfunction

  // bit i moves to 16*(i mod 4) + i/4
  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    t = '0;
    for (int i = 0; i < BLK_W; i++) begin
      t[(BLK_W / 4) * (i % 4) + (i / 4)] = s[i];
    end
    return t;
  endfunction

endpackage

// ----- src/p80_if.sv -----
// Valid/ready channel interfaces for plaintext requests and ciphertext results.
interface p80_pt_if import p80_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] plaintext;

  modport source (output valid, output plaintext, input ready);
  modport sink (input valid, input plaintext, output ready);
endinterface

interface p80_ct_if import p80_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] ciphertext;

  modport source (output valid, output ciphertext, input ready);
  modport sink (input valid, input ciphertext, output ready);
endinterface

// ----- src/p80_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module p80_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/p80_keysched.sv -----
// Key registers and key schedule unit: writes one round key per cycle into the store.
module p80_keysched import p80_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output ks_wr_t               ks_wr,
  output logic                 ks_busy
);

  logic [BLK_W-1:0]    key_lo_r, key_lo_nxt;
  logic [KEY_HI_W-1:0] key_hi_r, key_hi_nxt;
  logic [KEY_W-1:0]    work_r, work_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                key_wr;
  logic [KEY_W-1:0]    rot;
  logic [CNT_W-1:0]    cnt_inc;

  assign key_wr  = cfg_we && (cfg_index == CFG_KEY_LOW || cfg_index == CFG_KEY_HIGH);
  assign cnt_inc = cnt_r + CNT_W'(1);

  // rotate left by 61, S-box on the top nibble, round counter into bits 19..15
  always_comb begin
    rot          = {work_r[18:0], work_r[KEY_W-1:19]};
    rot[79:76]   = SBOX[rot[79:76]];
    rot[19:15]   = rot[19:15] ^ cnt_inc;
  end

  always_comb begin
    key_lo_nxt = key_lo_r;
    key_hi_nxt = key_hi_r;
    work_nxt   = work_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    if (key_wr) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_lo_nxt = cfg_data;
        CFG_KEY_HIGH: key_hi_nxt = cfg_data[KEY_HI_W-1:0];
        default:      key_lo_nxt = key_lo_r;
      endcase
      // restart the rebuild from the new key
      work_nxt = {key_hi_nxt, key_lo_nxt};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      work_nxt = rot;
      cnt_nxt  = cnt_inc;
      if (cnt_r == CNT_W'(LAST_KEY)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
      work_r   <= '0;
      cnt_r    <= '0;
      busy_r   <= 1'b1;
    end else begin
      key_lo_r <= key_lo_nxt;
      key_hi_r <= key_hi_nxt;
      work_r   <= work_nxt;
      cnt_r    <= cnt_nxt;
      busy_r   <= busy_nxt;
    end
  end

  assign ks_wr.we   = busy_r;
  assign ks_wr.addr = cnt_r[RK_AW-1:0];
  assign ks_wr.data = work_r[KEY_W-1:KEY_W-BLK_W];
  assign ks_busy    = busy_r;

  a_wr_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> busy_r && cnt_r == '0)
    else $error("key write did not restart the schedule");

  a_sched_ends: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == CNT_W'(LAST_KEY) && !key_wr |=> !busy_r)
    else $error("schedule ran past the last round key");

  a_sched_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !key_wr |=> !busy_r && $stable(work_r))
    else $error("schedule started without a key write");

endmodule

// ----- src/p80_round.sv -----
// Round engine: one PRESENT round per cycle with the round key read from the store.
module p80_round import p80_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ks_busy,
  input  logic [BLK_W-1:0] rk_rdata,
  output logic [RK_AW-1:0] rk_raddr,
  p80_pt_if.sink           in_ch,
  p80_ct_if.source         out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } st_t;

  st_t              state_r, state_nxt;
  logic [RK_AW-1:0] rnd_r, rnd_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0] out_data_r, out_data_nxt;
  logic             start, last, finish;
  logic [BLK_W-1:0] mixed;

  assign in_ch.ready = (state_r == ST_IDLE) && !ks_busy;
  assign start       = in_ch.valid && in_ch.ready;
  assign last        = (state_r == ST_RUN) && (rnd_r == LAST_KEY);
  assign finish      = last && (!out_valid_r || out_ch.ready);
  assign mixed       = blk_r ^ rk_rdata;

  // hold the last key address while the result slot is full
  always_comb begin
    if (state_r == ST_RUN) begin
      rk_raddr = (last && !finish) ? rnd_r : rnd_r + RK_AW'(1);
    end else begin
      rk_raddr = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    blk_nxt       = blk_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          blk_nxt   = in_ch.plaintext;
          rnd_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          out_data_nxt  = mixed;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!last) begin
          blk_nxt = perm_layer(sbox_layer(mixed));
          rnd_nxt = rnd_r + RK_AW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blk_r      <= blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ciphertext = out_data_r;

  a_rnd_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && rnd_r != LAST_KEY |=> state_r == ST_RUN &&
      rnd_r == $past(rnd_r) + RK_AW'(1))
    else $error("round counter skipped or stalled");

  a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN && rnd_r == LAST_KEY))
    else $error("result raised before the final key addition");

  a_no_start_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_RUN) |-> $past(!ks_busy))
    else $error("request started while round keys were being rebuilt");

endmodule

// ----- src/present80_block_encrypt.sv -----
// PRESENT-80 ECB encryptor: one 64-bit plaintext request in, one ciphertext out.
//
// Channels: in_ch carries plaintext requests, out_ch carries ciphertext
// results, both valid/ready; a transfer happens when valid and ready are high
// at a rising edge. The 80-bit key is written through cfg_we/cfg_index/
// cfg_data: index 0 sets key bits 63..0, index 1 sets bits 79..64 from the
// low 16 data bits; other indexes are dropped.
// Round keys live in a 32-entry RAM. A key write, and reset, starts a rebuild
// that writes one round key per cycle, so in_ch.ready stays low until the
// last round key is written. Write keys only while no request is in flight.
// An accepted request runs 31 rounds and then the final key addition, which
// raises out_ch.valid with the result. Steps run one per cycle, the final one
// only once the result slot is free, each using one RAM read. One request is
// worked on at a time; the next request is taken as soon as the result is
// registered, even while that result waits on out_ch.ready.
// If the receiver stalls with a result still held, the next block finishes its
// rounds and then holds before its final key addition until the slot drains.
// Reset (rst_n low, synchronous) clears the key to zero and rebuilds its schedule.
module present80_block_encrypt import p80_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  p80_pt_if.sink               in_ch,
  p80_ct_if.source             out_ch
);

  ks_wr_t           ks_wr;
  logic             ks_busy;
  logic [RK_AW-1:0] rk_raddr;
  logic [BLK_W-1:0] rk_rdata;

  p80_keysched u_keysched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ks_wr     (ks_wr),
    .ks_busy   (ks_busy)
  );

  p80_ram #(
    .WIDTH (BLK_W),
    .DEPTH (RK_DEPTH)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ks_wr.we),
    .waddr (ks_wr.addr),
    .wdata (ks_wr.data),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  p80_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .ks_busy  (ks_busy),
    .rk_rdata (rk_rdata),
    .rk_raddr (rk_raddr),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule
